[design/sed_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg
// Shared sizes, codes and controller/datapath types of the start/end-code
// packet deframer.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_FRAME   = 32;
    localparam int ADDR_W      = $clog2(MAX_FRAME);
    localparam int RUN_LIMIT   = 24;
    localparam int RUN_W       = $clog2(RUN_LIMIT + 1);
    localparam int PIDX_W      = 5;
    localparam int POS_CAP     = 1023;
    localparam int POS_W       = $clog2(POS_CAP + 1);
    localparam int PARAM_BASE  = 6;
    localparam int FRAME_OVERHEAD = 8;
    localparam int IDX_W       = $clog2(PARAM_BASE + (1 << BYTE_W));
    localparam int HDR_BYTES   = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int TDATA_W     = 72;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    typedef enum logic [1:0] {
        REG_START_CODE     = 2'd0,
        REG_END_CODE       = 2'd1,
        REG_DIRECTION_MASK = 2'd2,
        REG_COUNT_MASK     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_HUNT,
        S_FRAME,
        S_CSUM_RD,
        S_CSUM_LD,
        S_PARAM_RD,
        S_PARAM_LD
    } state_t;

    typedef struct packed {
        logic open_frame;
        logic store_byte;
        logic csum_read;
        logic csum_latch;
        logic param_read;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic rx_is_start;
        logic rx_is_end;
        logic out_free;
        logic run_last;
    } dp_status_t;

    typedef struct packed {
        logic              overflow;
        logic              bad_length;
        logic              last;
        logic [PIDX_W-1:0] param_index;
        logic [BYTE_W-1:0] param_byte;
        logic [BYTE_W-1:0] checksum;
        logic [BYTE_W-1:0] command_low;
        logic [BYTE_W-1:0] command_high;
        logic [BYTE_W-1:0] device_id;
        logic [BYTE_W-1:0] class_code;
        logic [BYTE_W-1:0] param_count;
        logic [BYTE_W-1:0] direction;
    } result_t;

endpackage
`default_nettype wire

[design/sed_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sed_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/sed_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sed_ctrl
// Controller: hunts for the start code, stores the frame, then steps the
// checksum read and one read/load pair per emitted result.
// ----------------------------------------------------------------------------
module sed_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  sed_pkg::dp_status_t status,
    output sed_pkg::dp_cmd_t    cmd
);
    import sed_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rx_ready   = 1'b0;
        case (state_reg)
            S_HUNT:
            begin
                rx_ready = 1'b1;
                if (rx_valid && status.rx_is_start)
                begin
                    cmd.open_frame = 1'b1;
                    state_next     = S_FRAME;
                end
            end
            S_FRAME:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    cmd.store_byte = 1'b1;
                    if (status.rx_is_end)
                    begin
                        state_next = S_CSUM_RD;
                    end
                end
            end
            S_CSUM_RD:
            begin
                cmd.csum_read = 1'b1;
                state_next    = S_CSUM_LD;
            end
            S_CSUM_LD:
            begin
                cmd.csum_latch = 1'b1;
                state_next     = S_PARAM_RD;
            end
            S_PARAM_RD:
            begin
                cmd.param_read = 1'b1;
                state_next     = S_PARAM_LD;
            end
            S_PARAM_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.run_last ? S_HUNT : S_PARAM_RD;
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/sed_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sed_datapath
// Datapath: configuration registers, byte counter, header capture, frame
// store, checksum and parameter fetch, output register.
// ----------------------------------------------------------------------------
module sed_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [sed_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sed_pkg::BYTE_W-1:0]        cfg_data,
    input  logic [sed_pkg::BYTE_W-1:0]        rx_byte,
    input  sed_pkg::dp_cmd_t                  cmd,
    output sed_pkg::dp_status_t               status,
    input  logic                              out_ready,
    output logic                              out_valid,
    output sed_pkg::result_t                  out_item
);
    import sed_pkg::*;

    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] end_code_reg;
    logic [BYTE_W-1:0] dir_mask_reg;
    logic [BYTE_W-1:0] count_mask_reg;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic              ovf_reg,  ovf_next;
    logic [RUN_W-1:0]  j_reg,    j_next;
    logic              out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0] hdr_reg  [HDR_BYTES];
    logic [BYTE_W-1:0] hdr_next [HDR_BYTES];
    logic [BYTE_W-1:0] hdr_val  [HDR_BYTES];
    logic [BYTE_W-1:0] count_reg,   count_next;
    logic              csum_ok_reg, csum_ok_next;
    logic [BYTE_W-1:0] csum_reg,    csum_next;
    logic              param_ok_reg, param_ok_next;
    result_t           out_item_reg, out_item_next;

    logic [BYTE_W-1:0] count_now;
    logic [POS_W-1:0]  stored;
    logic [IDX_W-1:0]  csum_idx;
    logic [IDX_W-1:0]  param_idx;
    logic [RUN_W-1:0]  j_inc;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= 8'd1;
            end_code_reg   <= 8'd4;
            dir_mask_reg   <= 8'd128;
            count_mask_reg <= 8'd127;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IDX_W'(REG_START_CODE))
            begin
                start_code_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_W'(REG_END_CODE))
            begin
                end_code_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_W'(REG_DIRECTION_MASK))
            begin
                dir_mask_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_W'(REG_COUNT_MASK))
            begin
                count_mask_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            hdr_val[k] = (pos_reg > POS_W'(k + 1)) ? hdr_reg[k] : '0;
        end
        count_now = hdr_val[0] & count_mask_reg;
        stored    = (pos_reg < POS_W'(MAX_FRAME)) ? pos_reg : POS_W'(MAX_FRAME);
        csum_idx  = IDX_W'(PARAM_BASE) + IDX_W'(count_now);
        param_idx = IDX_W'(PARAM_BASE) + IDX_W'(j_reg);
        j_inc     = j_reg + RUN_W'(1);
    end

    assign status.rx_is_start = (rx_byte == start_code_reg);
    assign status.rx_is_end   = (rx_byte == end_code_reg);
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.run_last    = (count_reg == '0) || (BYTE_W'(j_inc) == count_reg)
                                || (j_inc == RUN_W'(RUN_LIMIT));

    assign ram_we    = cmd.store_byte && (pos_reg < POS_W'(MAX_FRAME));
    assign ram_re    = cmd.csum_read || cmd.param_read;
    assign ram_raddr = cmd.csum_read ? csum_idx[ADDR_W-1:0] : param_idx[ADDR_W-1:0];

    sed_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        hdr_next       = hdr_reg;
        count_next     = count_reg;
        csum_ok_next   = csum_ok_reg;
        csum_next      = csum_reg;
        param_ok_next  = param_ok_reg;
        out_item_next  = out_item_reg;

        if (cmd.open_frame)
        begin
            pos_next = POS_W'(1);
            ovf_next = 1'b0;
        end
        if (cmd.store_byte)
        begin
            for (int k = 0; k < HDR_BYTES; k++)
            begin
                if (pos_reg == POS_W'(k + 1))
                begin
                    hdr_next[k] = rx_byte;
                end
            end
            if (pos_reg >= POS_W'(MAX_FRAME))
            begin
                ovf_next = 1'b1;
            end
            if (pos_reg < POS_W'(POS_CAP))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (cmd.csum_read)
        begin
            count_next   = count_now;
            csum_ok_next = POS_W'(csum_idx) < stored;
            j_next       = '0;
        end
        if (cmd.csum_latch)
        begin
            csum_next = csum_ok_reg ? ram_rdata : '0;
        end
        if (cmd.param_read)
        begin
            param_ok_next = (count_reg != '0) && (POS_W'(param_idx) < stored);
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next             = 1'b1;
            j_next                     = j_inc;
            out_item_next.direction    = hdr_val[0] & dir_mask_reg;
            out_item_next.param_count  = count_reg;
            out_item_next.class_code   = hdr_val[1];
            out_item_next.device_id    = hdr_val[2] - ASCII_ZERO;
            out_item_next.command_high = hdr_val[3];
            out_item_next.command_low  = hdr_val[4];
            out_item_next.checksum     = csum_reg;
            out_item_next.param_byte   = param_ok_reg ? ram_rdata : '0;
            out_item_next.param_index  = PIDX_W'(j_reg);
            out_item_next.last         = status.run_last;
            out_item_next.bad_length   = pos_reg != (POS_W'(FRAME_OVERHEAD)
                                                     + POS_W'(count_reg));
            out_item_next.overflow     = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg      <= hdr_next;
        count_reg    <= count_next;
        csum_ok_reg  <= csum_ok_next;
        csum_reg     <= csum_next;
        param_ok_reg <= param_ok_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

[design/soh_eot_packet_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// soh_eot_packet_deframer_unit
// Start/end-code packet deframer: hunts for the start code, stores a frame
// up to the end code and emits one beat per parameter with the header.
// ----------------------------------------------------------------------------
// Usage: tready stays high while hunting or storing, so every byte that does
// not close a frame is taken. A closing byte (end code) is followed by a
// checksum read and latch, then a read and load per result beat through the
// single read port of the 32-entry frame store; a run has one to 24 beats,
// the final one with tlast, and output backpressure stalls it. The input
// reopens as soon as the last beat of a run is loaded into the output
// register. Configuration writes are taken at any time but belong in idle.
module soh_eot_packet_deframer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // rx_byte [7:0]
    input  logic [sed_pkg::BYTE_W-1:0]    s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // direction [7:0], param_count [15:8], class_code [23:16],
    // device_id [31:24], command_high [39:32], command_low [47:40],
    // checksum [55:48], param_byte [63:56], param_index [68:64],
    // bad_length [69], overflow [70], zero [71]
    output logic [sed_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sed_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sed_pkg::BYTE_W-1:0]    cfg_data
);
    import sed_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    item;

    assign cfg_ready = 1'b1;

    sed_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (s_axis_tvalid),
        .rx_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sed_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_item  (item)
    );

    assign m_axis_tdata = {1'b0, item.overflow, item.bad_length, item.param_index,
                           item.param_byte, item.checksum, item.command_low,
                           item.command_high, item.device_id, item.class_code,
                           item.param_count, item.direction};
    assign m_axis_tlast = item.last;

    // closing byte stops the input until the run is out
    a_close_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store_byte && status.rx_is_end) |=> !s_axis_tready)
        else $error("input still ready after closing byte");

    // never overwrite a beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

endmodule
`default_nettype wire
